>>> rtl/core/affine_point_transform_macros.svh
// Assertion macros for the affine point transform block.
`ifndef AFFINE_POINT_TRANSFORM_MACROS_SVH
`define AFFINE_POINT_TRANSFORM_MACROS_SVH

`ifndef SYNTHESIS
`define APT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("apt assertion failed");
`define APT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("apt assertion failed");
`else
`define APT_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define APT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/core/apt_pkg.sv
// Shared types and constants of the affine point transform block.
`default_nettype none
package apt_pkg;
    localparam int FRAC_BITS   = 16;
    localparam int WORD_W      = 32;
    localparam int IDX_W       = 4;
    localparam int MAT_ROWS    = 4;
    localparam int MAT_COLS    = 3;
    localparam int MAT_ENTRIES = MAT_ROWS * MAT_COLS;
    localparam int PROD_W      = 2 * WORD_W;
    localparam int SUM_W       = PROD_W + 3;
    localparam int S_TDATA_W   = 136;
    localparam int M_TDATA_W   = 96;

    typedef enum logic {
        FUNC_LOAD  = 1'b0,
        FUNC_XFORM = 1'b1
    } t_func;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef t_word [MAT_ROWS-1:0]     t_col;
    typedef t_word [MAT_ENTRIES-1:0]  t_mat;

    typedef struct packed {
        logic ld_prod;
        logic ld_sum;
        logic ld_out;
    } t_stage_en;
endpackage
`default_nettype wire

>>> rtl/core/apt_matrix.sv
// Twelve-element matrix store written by load transactions.
`default_nettype none
module apt_matrix (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_we,
    input  wire [apt_pkg::IDX_W-1:0] i_idx,
    input  wire apt_pkg::t_word   i_value,
    output apt_pkg::t_mat         o_mat
);
    import apt_pkg::*;

    t_mat r_mat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat <= '0;
        end else if (i_we && (i_idx < IDX_W'(MAT_ENTRIES))) begin
            r_mat[i_idx] <= i_value;
        end
    end

    assign o_mat = r_mat;
endmodule
`default_nettype wire

>>> rtl/core/apt_pipe_ctrl.sv
// Valid tracking and stage enables for the three-stage transform pipeline.
`default_nettype none
`include "affine_point_transform_macros.svh"
module apt_pipe_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_s_valid,
    input  wire                 i_is_xform,
    input  wire                 i_m_ready,
    output logic                o_s_ready,
    output logic                o_m_valid,
    output apt_pkg::t_stage_en  o_en
);
    import apt_pkg::*;

    logic r_v_prod;
    logic r_v_sum;
    logic r_v_out;
    logic adv_out;
    logic adv_sum;
    logic adv_prod;
    logic s_acc;

    assign adv_out  = !r_v_out || i_m_ready;
    assign adv_sum  = !r_v_sum || adv_out;
    assign adv_prod = !r_v_prod || adv_sum;
    assign s_acc    = i_s_valid && adv_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_prod <= 1'b0;
            r_v_sum  <= 1'b0;
            r_v_out  <= 1'b0;
        end else begin
            if (adv_prod) begin
                r_v_prod <= s_acc && i_is_xform;
            end
            if (adv_sum) begin
                r_v_sum <= r_v_prod;
            end
            if (adv_out) begin
                r_v_out <= r_v_sum;
            end
        end
    end

    assign o_s_ready      = adv_prod;
    assign o_m_valid      = r_v_out;
    assign o_en.ld_prod   = s_acc && i_is_xform;
    assign o_en.ld_sum    = adv_sum && r_v_prod;
    assign o_en.ld_out    = adv_out && r_v_sum;

    `APT_ASSERT_NEXT(a_xform_enters, i_clk, i_rst_n, s_acc && i_is_xform, r_v_prod)
    `APT_ASSERT_NEXT(a_load_no_result, i_clk, i_rst_n, s_acc && !i_is_xform, !r_v_prod)
    `APT_ASSERT_SAME(a_full_stall, i_clk, i_rst_n,
        r_v_prod && r_v_sum && r_v_out && !i_m_ready, !o_s_ready)
    `APT_ASSERT_NEXT(a_sum_held, i_clk, i_rst_n,
        r_v_sum && r_v_out && !i_m_ready, r_v_sum)
endmodule
`default_nettype wire

>>> rtl/core/apt_lane.sv
// One output column: three products, exact sum with translation, floor shift and saturation.
`default_nettype none
module apt_lane (
    input  wire                 i_clk,
    input  wire apt_pkg::t_stage_en i_en,
    input  wire apt_pkg::t_word i_x,
    input  wire apt_pkg::t_word i_y,
    input  wire apt_pkg::t_word i_z,
    input  wire apt_pkg::t_col  i_col,
    output apt_pkg::t_word      o_result
);
    import apt_pkg::*;

    logic signed [PROD_W-1:0] n_p0, n_p1, n_p2;
    logic signed [PROD_W-1:0] r_p0, r_p1, r_p2;
    t_word                    r_trans;
    logic signed [SUM_W-1:0]  n_sum;
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [SUM_W-1:0]  shifted;
    logic [SUM_W-WORD_W:0]    upper;
    t_word                    n_out;
    t_word                    r_out;

    assign n_p0 = i_x * i_col[0];
    assign n_p1 = i_y * i_col[1];
    assign n_p2 = i_z * i_col[2];

    always_ff @(posedge i_clk) begin
        if (i_en.ld_prod) begin
            r_p0    <= n_p0;
            r_p1    <= n_p1;
            r_p2    <= n_p2;
            r_trans <= i_col[MAT_ROWS-1];
        end
    end

    assign n_sum = SUM_W'(r_p0) + SUM_W'(r_p1) + SUM_W'(r_p2)
                 + (SUM_W'(r_trans) <<< FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (i_en.ld_sum) begin
            r_sum <= n_sum;
        end
    end

    assign shifted = r_sum >>> FRAC_BITS;
    assign upper   = shifted[SUM_W-1:WORD_W-1];

    always_comb begin
        if ((&upper) || !(|upper)) begin
            n_out = shifted[WORD_W-1:0];
        end else if (upper[SUM_W-WORD_W]) begin
            n_out = {1'b1, {(WORD_W-1){1'b0}}};
        end else begin
            n_out = {1'b0, {(WORD_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.ld_out) begin
            r_out <= n_out;
        end
    end

    assign o_result = r_out;
endmodule
`default_nettype wire

>>> rtl/core/affine_point_transform.sv
// Top level of the affine 4x3 vertex transform engine.
//
//  channel   direction  tdata fields (low bit up)                           tuser
//  s_axis    in         matrix_index[3:0] matrix_value in_x in_y in_z, pad   func
//  m_axis    out        out_x out_y out_z                                    none
//
// A transform transaction passes the product, sum and output registers before its result is valid.
// One transaction per cycle when not stalled, by three parallel lane multiplier banks.
// A load transaction writes the matrix at acceptance and yields no result.
// Reset clears the matrix and the pipeline valid flags.
// A stalled output holds the pipeline; input is refused only when every stage is full.
`default_nettype none
module affine_point_transform (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    // matrix_index[3:0], matrix_value[35:4], in_x[67:36], in_y[99:68], in_z[131:100]
    input  wire [apt_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // func[0]
    input  wire [0:0]                        s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64]
    output logic [apt_pkg::M_TDATA_W-1:0]    m_axis_tdata
);
    import apt_pkg::*;

    t_stage_en          en;
    t_mat               mat;
    logic               is_xform;
    logic               load_we;
    logic [IDX_W-1:0]   idx;
    t_word              mval;
    t_word              px, py, pz;
    t_word [MAT_COLS-1:0] res;

    assign is_xform = (t_func'(s_axis_tuser[0]) == FUNC_XFORM);
    assign idx      = s_axis_tdata[IDX_W-1:0];
    assign mval     = s_axis_tdata[IDX_W +: WORD_W];
    assign px       = s_axis_tdata[IDX_W + WORD_W +: WORD_W];
    assign py       = s_axis_tdata[IDX_W + 2*WORD_W +: WORD_W];
    assign pz       = s_axis_tdata[IDX_W + 3*WORD_W +: WORD_W];
    assign load_we  = s_axis_tvalid && s_axis_tready && !is_xform;

    apt_pipe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_valid  (s_axis_tvalid),
        .i_is_xform (is_xform),
        .i_m_ready  (m_axis_tready),
        .o_s_ready  (s_axis_tready),
        .o_m_valid  (m_axis_tvalid),
        .o_en       (en)
    );

    apt_matrix u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (load_we),
        .i_idx   (idx),
        .i_value (mval),
        .o_mat   (mat)
    );

    for (genvar c = 0; c < MAT_COLS; c++) begin : g_lane
        t_col col;
        for (genvar r = 0; r < MAT_ROWS; r++) begin : g_row
            assign col[r] = mat[r*MAT_COLS + c];
        end

        apt_lane u_lane (
            .i_clk    (i_clk),
            .i_en     (en),
            .i_x      (px),
            .i_y      (py),
            .i_z      (pz),
            .i_col    (col),
            .o_result (res[c])
        );
    end

    assign m_axis_tdata = res;
endmodule
`default_nettype wire

>>> sim/tb_affine_point_transform.sv
// Self-checking testbench for the affine 4x3 vertex transform engine.
module tb_affine_point_transform;
    timeunit 1ns;
    timeprecision 1ps;

    import apt_pkg::*;

    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_OPS   = 1300;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_AT      = 400;
    localparam int HOLD_CYCLES  = 300;
    localparam int CALM_TAIL    = 150;
    localparam int SETTLE       = 10;

    localparam logic signed [79:0] SAT_HI = 80'sd2147483647;
    localparam logic signed [79:0] SAT_LO = -80'sd2147483648;
    localparam t_word WORD_MAX = 32'sh7fffffff;
    localparam t_word WORD_MIN = 32'sh80000000;
    localparam t_word ONE      = 32'sh00010000;

    typedef struct {
        t_func      func;
        logic [3:0] idx;
        t_word      value;
        t_word      x;
        t_word      y;
        t_word      z;
        bit         drain_first;
    } t_vertex_op;

    typedef struct packed {
        t_word z;
        t_word y;
        t_word x;
    } t_point;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // matrix_index, matrix_value, in_x, in_y, in_z, zero pad
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    // func
    logic [0:0]           s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // out_x, out_y, out_z
    logic [M_TDATA_W-1:0] m_axis_tdata;

    t_vertex_op pending_ops[$];
    t_point     expected_points[$];
    t_word      matrix_model[MAT_ENTRIES];

    int         total_ops = 0;
    int         accepted_ops = 0;
    int         err_count = 0;
    int         cycle_count = 0;
    logic       in_fire = 1'b0;
    int         tx_gap = 0;
    int         rx_gap = 0;
    int         hold_left = 0;
    bit         hold_done = 1'b0;
    logic       hold_active = 1'b0;
    t_vertex_op tx_op;

    affine_point_transform u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_word saturate(input logic signed [79:0] acc);
        if (acc > SAT_HI) return WORD_MAX;
        if (acc < SAT_LO) return WORD_MIN;
        return acc[31:0];
    endfunction

    function automatic t_point transform_point(input t_word x, input t_word y, input t_word z);
        logic signed [79:0] wx, wy, wz, m0, m1, m2, mt, acc;
        t_word              col_out[MAT_COLS];
        t_point             res;
        wx = x;
        wy = y;
        wz = z;
        for (int c = 0; c < MAT_COLS; c++) begin
            m0 = matrix_model[0 * MAT_COLS + c];
            m1 = matrix_model[1 * MAT_COLS + c];
            m2 = matrix_model[2 * MAT_COLS + c];
            mt = matrix_model[3 * MAT_COLS + c];
            acc = wx * m0 + wy * m1 + wz * m2 + (mt <<< FRAC_BITS);
            col_out[c] = saturate(acc >>> FRAC_BITS);
        end
        res.x = col_out[0];
        res.y = col_out[1];
        res.z = col_out[2];
        return res;
    endfunction

    function automatic t_word rand_fixed();
        case ($urandom_range(0, 9)) inside
            [0:3]: return $urandom;
            [4:7]: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
            8: begin
                case ($urandom_range(0, 3))
                    0: return WORD_MAX;
                    1: return WORD_MIN;
                    2: return '0;
                    default: return -32'sd1;
                endcase
            end
            default: return ($urandom_range(0, 1) ? ONE : -ONE) + $signed($urandom_range(0, 255));
        endcase
    endfunction

    function automatic bit idling_allowed();
        return ((accepted_ops / 200) % 4 != 3) && (total_ops - accepted_ops > CALM_TAIL);
    endfunction

    task automatic add_load(input int idx, input t_word value);
        t_vertex_op op;
        op.func = FUNC_LOAD;
        op.idx = idx[3:0];
        op.value = value;
        op.x = $urandom;
        op.y = $urandom;
        op.z = $urandom;
        op.drain_first = 1'b0;
        pending_ops.push_back(op);
        total_ops++;
    endtask

    task automatic add_point(input t_word x, input t_word y, input t_word z,
                             input bit drain_first);
        t_vertex_op op;
        op.func = FUNC_XFORM;
        op.idx = $urandom_range(0, 15);
        op.value = $urandom;
        op.x = x;
        op.y = y;
        op.z = z;
        op.drain_first = drain_first;
        pending_ops.push_back(op);
        total_ops++;
    endtask

    task automatic report_mismatch(input string what, input t_word got, input t_word want);
        err_count++;
        $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_affine_point_transform: FAIL");
            $finish;
        end
    end

    // The output side is checked before the input side so that a stray result
    // can never consume an expectation pushed at the same edge.
    always @(posedge i_clk) begin
        t_point got;
        t_point want;
        if (!i_rst_n) begin
            in_fire <= 1'b0;
            for (int i = 0; i < MAT_ENTRIES; i++) matrix_model[i] = '0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.x = m_axis_tdata[31:0];
                got.y = m_axis_tdata[63:32];
                got.z = m_axis_tdata[95:64];
                if (expected_points.size() == 0) begin
                    report_mismatch("unexpected transaction", got.x, '0);
                end else begin
                    want = expected_points.pop_front();
                    if (got.x !== want.x) report_mismatch("out_x", got.x, want.x);
                    if (got.y !== want.y) report_mismatch("out_y", got.y, want.y);
                    if (got.z !== want.z) report_mismatch("out_z", got.z, want.z);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (t_func'(s_axis_tuser[0]) == FUNC_LOAD) begin
                    if (s_axis_tdata[3:0] < MAT_ENTRIES) begin
                        matrix_model[s_axis_tdata[3:0]] = s_axis_tdata[35:4];
                    end
                end else begin
                    expected_points.push_back(transform_point(s_axis_tdata[67:36],
                        s_axis_tdata[99:68], s_axis_tdata[131:100]));
                end
                accepted_ops++;
            end
            in_fire <= s_axis_tvalid && s_axis_tready;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_fire) begin
            if (tx_gap > 0) begin
                tx_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_ops.size() == 0) begin
                s_axis_tvalid <= 1'b0;
            end else if (pending_ops[0].drain_first && expected_points.size() != 0) begin
                s_axis_tvalid <= 1'b0;
            end else begin
                tx_op = pending_ops.pop_front();
                s_axis_tdata <= {4'b0, tx_op.z, tx_op.y, tx_op.x, tx_op.value, tx_op.idx};
                s_axis_tuser <= tx_op.func;
                s_axis_tvalid <= 1'b1;
                if (idling_allowed() && $urandom_range(0, 9) == 0) tx_gap = $urandom_range(1, 7);
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            hold_active <= 1'b0;
        end else if (!hold_done && accepted_ops >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            hold_active <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left--;
            hold_active <= (hold_left > 0);
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_active) begin
            m_axis_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (idling_allowed() && $urandom_range(0, 7) == 0) rx_gap = $urandom_range(1, 7);
        end
    end

    initial begin
        int kind;
        // Directed part: zero matrix, identity with translation, ignored indexes,
        // flooring of negative sums and saturation at both ends.
        add_point(WORD_MAX, WORD_MIN, -32'sd1, 1'b0);
        for (int i = 0; i < 9; i++) add_load(i, (i % 4 == 0) ? ONE : '0);
        add_load(9, 32'sh0001_8000);
        add_load(10, -ONE);
        add_load(11, '0);
        for (int i = 12; i < 16; i++) add_load(i, WORD_MAX);
        add_point(ONE, -32'sh0002_8000, WORD_MIN, 1'b0);
        add_load(0, 32'sh0000_8000);
        add_point(-32'sd1, 32'sd1, '0, 1'b0);
        add_load(0, WORD_MIN);
        add_load(3, WORD_MIN);
        add_load(6, WORD_MIN);
        add_point(WORD_MIN, WORD_MIN, WORD_MIN, 1'b0);
        add_point(WORD_MAX, WORD_MAX, WORD_MAX, 1'b0);
        add_load(11, WORD_MAX);
        add_point('0, '0, '0, 1'b1);

        for (int i = 0; i < MAT_ENTRIES; i++) add_load(i, rand_fixed());
        for (int n = 0; n < RANDOM_OPS; n++) begin
            kind = $urandom_range(0, 99);
            if (kind == 0) begin
                for (int i = 0; i < MAT_ENTRIES; i++) add_load(i, rand_fixed());
            end else if (kind < 12) begin
                add_load($urandom_range(0, 15), rand_fixed());
            end else begin
                add_point(rand_fixed(), rand_fixed(), rand_fixed(), n == 700 || n == 1000);
            end
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_ops < total_ops || expected_points.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (expected_points.size() != 0) begin
            report_mismatch("missing transaction", '0, expected_points[0].x);
        end
        if (err_count == 0) begin
            $display("tb_affine_point_transform: PASS");
        end else begin
            $display("tb_affine_point_transform: FAIL");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/apt_pkg.sv
rtl/core/apt_matrix.sv
rtl/core/apt_pipe_ctrl.sv
rtl/core/apt_lane.sv
rtl/core/affine_point_transform.sv
sim/tb_affine_point_transform.sv
